FILE: rtl/sc2a_pkg.sv
// Shared types, constants and scancode set 1 translation tables for the
// scancode to ASCII FIFO block. Depends on nothing.
package sc2a_pkg;

    // Default character buffer depth
    localparam int FIFO_DEPTH_DEFAULT = 256;

    // Command codes
    localparam logic CMD_SCANCODE = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    // Shift key codes and the break marker
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam int         SC_BREAK_BIT    = 7;

    // Request transaction
    typedef struct packed {
        logic       cmd;
        logic [7:0] scancode;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic       read_valid;
        logic [6:0] char_out;
        logic       not_empty;
        logic       dropped;
    } rsp_t;

    // Unshifted key map; zero for keys with no character
    function automatic logic [6:0] plain_char(input logic [6:0] code);
        logic [7:0] c;
        unique case (code)
            7'h02: c = "1";
            7'h03: c = "2";
            7'h04: c = "3";
            7'h05: c = "4";
            7'h06: c = "5";
            7'h07: c = "6";
            7'h08: c = "7";
            7'h09: c = "8";
            7'h0A: c = "9";
            7'h0B: c = "0";
            7'h0C: c = "-";
            7'h0D: c = "=";
            7'h0E: c = 8'd8;
            7'h0F: c = 8'd9;
            7'h10: c = "q";
            7'h11: c = "w";
            7'h12: c = "e";
            7'h13: c = "r";
            7'h14: c = "t";
            7'h15: c = "y";
            7'h16: c = "u";
            7'h17: c = "i";
            7'h18: c = "o";
            7'h19: c = "p";
            7'h1A: c = "[";
            7'h1B: c = "]";
            7'h1C: c = 8'd10;
            7'h1E: c = "a";
            7'h1F: c = "s";
            7'h20: c = "d";
            7'h21: c = "f";
            7'h22: c = "g";
            7'h23: c = "h";
            7'h24: c = "j";
            7'h25: c = "k";
            7'h26: c = "l";
            7'h27: c = ";";
            7'h28: c = 8'h27;
            7'h29: c = 8'h60;
            7'h2B: c = 8'h5C;
            7'h2C: c = "z";
            7'h2D: c = "x";
            7'h2E: c = "c";
            7'h2F: c = "v";
            7'h30: c = "b";
            7'h31: c = "n";
            7'h32: c = "m";
            7'h33: c = ",";
            7'h34: c = ".";
            7'h35: c = "/";
            7'h37: c = "*";
            7'h39: c = " ";
            7'h47: c = "7";
            7'h48: c = "8";
            7'h49: c = "9";
            7'h4A: c = "-";
            7'h4B: c = "4";
            7'h4C: c = "5";
            7'h4D: c = "6";
            7'h4E: c = "+";
            7'h4F: c = "1";
            7'h50: c = "2";
            7'h51: c = "3";
            7'h52: c = "0";
            7'h53: c = ".";
            default: c = 8'h00;
        endcase
        return c[6:0];
    endfunction

    // Shifted key map; keys that shift does not change fall back to plain
    function automatic logic [6:0] shifted_char(input logic [6:0] code);
        logic [7:0] c;
        unique case (code)
            7'h02: c = "!";
            7'h03: c = "@";
            7'h04: c = "#";
            7'h05: c = "$";
            7'h06: c = 8'h25;
            7'h07: c = "^";
            7'h08: c = "&";
            7'h09: c = "*";
            7'h0A: c = "(";
            7'h0B: c = ")";
            7'h0C: c = "_";
            7'h0D: c = "+";
            7'h10: c = "Q";
            7'h11: c = "W";
            7'h12: c = "E";
            7'h13: c = "R";
            7'h14: c = "T";
            7'h15: c = "Y";
            7'h16: c = "U";
            7'h17: c = "I";
            7'h18: c = "O";
            7'h19: c = "P";
            7'h1A: c = "{";
            7'h1B: c = "}";
            7'h1E: c = "A";
            7'h1F: c = "S";
            7'h20: c = "D";
            7'h21: c = "F";
            7'h22: c = "G";
            7'h23: c = "H";
            7'h24: c = "J";
            7'h25: c = "K";
            7'h26: c = "L";
            7'h27: c = ":";
            7'h28: c = 8'h22;
            7'h29: c = "~";
            7'h2B: c = "|";
            7'h2C: c = "Z";
            7'h2D: c = "X";
            7'h2E: c = "C";
            7'h2F: c = "V";
            7'h30: c = "B";
            7'h31: c = "N";
            7'h32: c = "M";
            7'h33: c = "<";
            7'h34: c = ">";
            7'h35: c = "?";
            default: c = {1'b0, plain_char(code)};
        endcase
        return c[6:0];
    endfunction

endpackage

FILE: rtl/scancode_to_ascii_fifo.sv
// Scancode set 1 to ASCII translator with a character ring buffer.
// Depends on sc2a_pkg for transaction types, key codes and key maps.
//
// Usage:
//   The req channel carries one transaction per command: cmd selects
//   either a raw scancode byte or a read of one buffered character.
//   Shift make/break codes track the shift state; other make codes with a
//   character are mapped to ASCII and pushed into a buffer of FIFO_DEPTH
//   slots, one of which stays free, so up to FIFO_DEPTH-1 characters are
//   held. A push into a full buffer is discarded and flagged with dropped.
//   Every req transaction gives exactly one rsp transaction. A read on an
//   empty buffer answers read_valid=0 and char_out=0; it never blocks.
// Timing:
//   One transaction per cycle sustained unless rsp stalls. The response
//   appears in the cycle after acceptance, from the synchronous read of
//   the character memory, and sits in the output register until taken.
//   While rsp is stalled with a response pending, req is stalled too.
// Reset:
//   rst_n clears the shift state, both pointers and the output valid.
//   Memory contents are not cleared; only written slots are ever read.
module scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  sc2a_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output sc2a_pkg::rsp_t  rsp
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

    // Character memory
    logic [6:0] mem [FIFO_DEPTH];
    logic [6:0] rdata_reg;

    // Control state
    logic             shift_reg, shift_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;

    // Output register
    logic       out_valid_reg;
    logic       read_valid_reg, read_valid_next;
    logic       not_empty_reg, not_empty_next;
    logic       dropped_reg, dropped_next;

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [6:0]       char_val;
    logic [PTR_W-1:0] wr_inc;
    logic [PTR_W-1:0] rd_inc;
    logic             is_make;

    assign req_stall = out_valid_reg & rsp_stall;
    assign accept    = req_valid & ~req_stall;

    assign wr_inc  = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc  = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
    assign is_make = ~req.scancode[sc2a_pkg::SC_BREAK_BIT];

    // Key map lookup with the current shift state
    assign char_val = shift_reg ? sc2a_pkg::shifted_char(req.scancode[6:0])
                                : sc2a_pkg::plain_char(req.scancode[6:0]);

    // Command decode and pointer update
    always_comb
    begin
        shift_next      = shift_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        read_valid_next = 1'b0;
        dropped_next    = 1'b0;
        if (accept)
        begin
            unique case (req.cmd)
                sc2a_pkg::CMD_SCANCODE:
                begin
                    priority if (req.scancode == sc2a_pkg::SC_LSHIFT_MAKE ||
                                 req.scancode == sc2a_pkg::SC_RSHIFT_MAKE)
                    begin
                        shift_next = 1'b1;
                    end
                    else if (req.scancode == sc2a_pkg::SC_LSHIFT_BREAK ||
                             req.scancode == sc2a_pkg::SC_RSHIFT_BREAK)
                    begin
                        shift_next = 1'b0;
                    end
                    else if (is_make && char_val != 7'd0)
                    begin
                        if (wr_inc == rd_ptr_reg)
                        begin
                            dropped_next = 1'b1;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_ptr_next = wr_inc;
                        end
                    end
                    else
                    begin
                        shift_next = shift_reg;
                    end
                end
                sc2a_pkg::CMD_READ:
                begin
                    if (wr_ptr_reg != rd_ptr_reg)
                    begin
                        rd_en           = 1'b1;
                        read_valid_next = 1'b1;
                        rd_ptr_next     = rd_inc;
                    end
                end
                default:
                begin
                    shift_next = shift_reg;
                end
            endcase
        end
        not_empty_next = (wr_ptr_next != rd_ptr_next);
    end

    // Memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= char_val;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg  <= shift_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload, loaded with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_valid_reg <= read_valid_next;
            not_empty_reg  <= not_empty_next;
            dropped_reg    <= dropped_next;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp.read_valid  = read_valid_reg;
    assign rsp.char_out    = read_valid_reg ? rdata_reg : 7'd0;
    assign rsp.not_empty   = not_empty_reg;
    assign rsp.dropped     = dropped_reg;

`ifndef SYNTHESIS
    // Every accepted transaction yields a response in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted transaction produced no response");

    // A drop means the buffer was full, so it cannot be empty afterwards
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.dropped) |-> rsp.not_empty)
        else $error("drop reported with empty buffer");

    // A pop and a drop never come from the same transaction
    a_pop_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.read_valid && rsp.dropped))
        else $error("read and drop in one response");

    // Pointers stay inside the buffer
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= LAST_SLOT) && (rd_ptr_reg <= LAST_SLOT))
        else $error("pointer out of range");

    // Write and read never target memory in the same cycle
    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("simultaneous memory write and read");
`endif

endmodule
